// ===== hdl/pbkf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbkf_pkg
// Shared types, widths, register codes and reset values of the peak-burst
// Kalman filter.
// ----------------------------------------------------------------------------
package pbkf_pkg;

   localparam int CHANNELS = 6;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CHAN_W   = 3;
   localparam int SAMPLE_W = 12;
   localparam int COUNT_W  = 8;
   localparam int COV_W    = 32;
   localparam int K_FRAC   = 24;
   localparam int K_W      = K_FRAC + 1;

   localparam logic [K_W-1:0] K_ONE = {1'b1, {K_FRAC{1'b0}}};

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_BURST_LEN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROC_NOISE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_NOISE = 2'd2;

   localparam logic [COUNT_W-1:0] BURST_LEN_RST  = 8'd16;
   localparam logic [COV_W-1:0]   PROC_NOISE_RST = 32'd429497;
   localparam logic [COV_W-1:0]   MEAS_NOISE_RST = 32'd2147484;

   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic [SAMPLE_W-1:0] peak;
      logic [SAMPLE_W-1:0] est;
      logic [COV_W-1:0]    cov;
   } chan_entry_type;

   typedef struct packed {
      logic            en;
      logic [CH_W-1:0] addr;
   } ram_rd_type;

   typedef struct packed {
      logic            en;
      logic [CH_W-1:0] addr;
      chan_entry_type  data;
   } ram_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV_START,
      ST_DIV,
      ST_UPDATE,
      ST_WRITE
   } state_type;

endpackage
`default_nettype wire

// ===== hdl/pbkf_state_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbkf_state_ram
// Per-channel state memory with one write port and one registered read port.
// Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module pbkf_state_ram import pbkf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  ram_rd_type     ram_rd,
   input  ram_wr_type     ram_wr,
   output chan_entry_type rd_data
);

   chan_entry_type      mem [CHANNELS];
   logic [CHANNELS-1:0] valid_ff;
   logic [CHANNELS-1:0] valid_in;
   chan_entry_type      rdata_ff;
   logic                rvalid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ram_wr.en) begin
         valid_in[ram_wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_wr.en) begin
         mem[ram_wr.addr] <= ram_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_rd.en) begin
         rdata_ff  <= mem[ram_rd.addr];
         rvalid_ff <= valid_ff[ram_rd.addr];
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule
`default_nettype wire

// ===== hdl/pbkf_gain_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbkf_gain_div
// Restoring divider for the Kalman gain K = floor(P1 * 2^24 / (P1 + R)),
// one quotient bit per cycle. A zero denominator gives a gain of zero.
// ----------------------------------------------------------------------------
module pbkf_gain_div import pbkf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [COV_W-1:0] p1,
   input  logic [COV_W-1:0] meas_noise,
   output logic             done,
   output logic [K_W-1:0]   gain
);

   localparam int DEN_W  = COV_W + 1;
   localparam int REM_W  = COV_W + 2;
   localparam int STEP_W = $clog2(K_FRAC + 1);

   logic [DEN_W-1:0]  den_ff, den_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [K_W-1:0]    quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic [REM_W-1:0]  rem_shift;
   logic [REM_W-1:0]  rem_diff;
   logic              take;

   always_comb begin
      den_in    = den_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      busy_in   = busy_ff;
      rem_shift = {rem_ff[REM_W-2:0], 1'b0};
      rem_diff  = rem_shift - {1'b0, den_ff};
      take      = (rem_shift >= {1'b0, den_ff});
      if (start) begin
         den_in  = {1'b0, p1} + {1'b0, meas_noise};
         busy_in = 1'b1;
         if (den_in == '0) begin
            rem_in  = '0;
            quo_in  = '0;
            step_in = '0;
         end else if ({1'b0, p1} >= den_in) begin
            // Only reached with R at zero: the gain is exactly one.
            rem_in  = '0;
            quo_in  = K_W'(1);
            step_in = STEP_W'(K_FRAC);
         end else begin
            rem_in  = {1'b0, {1'b0, p1}};
            quo_in  = '0;
            step_in = STEP_W'(K_FRAC);
         end
      end else if (busy_ff) begin
         if (step_ff != '0) begin
            step_in = step_ff - STEP_W'(1);
            quo_in  = {quo_ff[K_W-2:0], take};
            rem_in  = take ? rem_diff : rem_shift;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign done = busy_ff && (step_ff == '0);
   assign gain = quo_ff;

endmodule
`default_nettype wire

// ===== hdl/pbkf_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbkf_update
// Estimate and covariance update, one multiplication per cycle:
// est' = (est*(1-K) + z*K) >> 24 and P' = (P1*(1-K)) >> 24.
// ----------------------------------------------------------------------------
module pbkf_update import pbkf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [K_W-1:0]      gain,
   input  logic [SAMPLE_W-1:0] est,
   input  logic [SAMPLE_W-1:0] peak,
   input  logic [COV_W-1:0]    p1,
   output logic                done,
   output logic [SAMPLE_W-1:0] est_new,
   output logic [COV_W-1:0]    cov_new
);

   localparam int ACC_W      = SAMPLE_W + K_W + 1;
   localparam int CPROD_W    = COV_W + K_W;
   localparam int UPD_STAGES = 4;

   logic [K_W-1:0]        gain_ff;
   logic [K_W-1:0]        omk_ff;
   logic [ACC_W-1:0]      acc_ff;
   logic [CPROD_W-1:0]    cprod_ff;
   logic [UPD_STAGES-1:0] stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= {stage_ff[UPD_STAGES-2:0], start};
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         gain_ff <= gain;
         omk_ff  <= K_ONE - gain;
      end
      if (stage_ff[0]) begin
         acc_ff <= ACC_W'(est) * ACC_W'(omk_ff);
      end
      if (stage_ff[1]) begin
         acc_ff <= acc_ff + ACC_W'(peak) * ACC_W'(gain_ff);
      end
      if (stage_ff[2]) begin
         cprod_ff <= CPROD_W'(p1) * CPROD_W'(omk_ff);
      end
   end

   assign done    = stage_ff[UPD_STAGES-1];
   assign est_new = acc_ff[K_FRAC +: SAMPLE_W];
   assign cov_new = cprod_ff[K_FRAC +: COV_W];

endmodule
`default_nettype wire

// ===== hdl/peak_burst_kalman_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// peak_burst_kalman_filter
// Per-channel burst peak detector feeding a scalar Kalman filter step.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_ready  req_channel, req_sample
//   rsp_      out        rsp_valid/rsp_ready  rsp_out_channel, rsp_filtered_value
//   csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// A sample that does not complete a burst is transferred, then the state
// memory is read and written back. A burst-completing sample goes through
// transfer, read, divider load, the divider steps, the update steps and the
// write-back. When the gain denominator is zero the divider finishes without
// stepping through the quotient bits. A sample on an unused channel is dropped
// at its transfer and the block stays idle. Reset clears the state memory at
// once through per-entry valid bits, so there is no clearing pass. The result
// write-back waits while an earlier result transfer is still pending; csr writes
// are taken every cycle.
// ----------------------------------------------------------------------------
module peak_burst_kalman_filter import pbkf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CHAN_W-1:0]     req_channel,
   input  logic [SAMPLE_W-1:0]   req_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAN_W-1:0]     rsp_out_channel,
   output logic [SAMPLE_W-1:0]   rsp_filtered_value,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CHX_W = 5;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0] burst_len_ff;
   logic [COV_W-1:0]   proc_noise_ff;
   logic [COV_W-1:0]   meas_noise_ff;

   logic [CH_W-1:0]     ch_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] peak_ff;
   logic [SAMPLE_W-1:0] est_ff;
   logic [COV_W-1:0]    p1_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]   rsp_channel_ff;
   logic [SAMPLE_W-1:0] rsp_value_ff;

   logic [CHX_W-1:0]    chan_ext;
   logic [CH_W-1:0]     ch_idx;
   logic                ch_in_range;
   logic                req_fire;
   chan_entry_type      rd_data_w;
   chan_entry_type      entry;
   logic [SAMPLE_W-1:0] peak_new;
   logic [COUNT_W-1:0]  need;
   logic                burst_done;
   logic [COV_W:0]      cov_sum;
   logic [COV_W-1:0]    p1_sat;
   logic                rsp_free;

   ram_rd_type          ram_rd;
   ram_wr_type          ram_wr;
   logic                div_start;
   logic                div_done;
   logic [K_W-1:0]      gain;
   logic                upd_start;
   logic                upd_done;
   logic [SAMPLE_W-1:0] est_new;
   logic [COV_W-1:0]    cov_new;
   logic                capture;
   logic                rsp_load;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_len_ff  <= BURST_LEN_RST;
         proc_noise_ff <= PROC_NOISE_RST;
         meas_noise_ff <= MEAS_NOISE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BURST_LEN:  burst_len_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_PROC_NOISE: proc_noise_ff <= csr_wdata[COV_W-1:0];
            CSR_MEAS_NOISE: meas_noise_ff <= csr_wdata[COV_W-1:0];
            default: ;
         endcase
      end
   end

   // Datapath terms.
   assign chan_ext    = {{(CHX_W-CHAN_W){1'b0}}, req_channel};
   assign ch_idx      = chan_ext[CH_W-1:0];
   assign ch_in_range = (chan_ext < CHX_W'(CHANNELS));
   assign req_fire    = req_valid && req_ready;
   assign entry       = rd_data_w;
   assign peak_new    = (sample_ff > entry.peak) ? sample_ff : entry.peak;
   assign need        = (burst_len_ff == '0) ? COUNT_W'(1) : burst_len_ff;
   assign burst_done  = (({1'b0, entry.count} + (COUNT_W+1)'(1)) >= {1'b0, need});
   assign cov_sum     = {1'b0, entry.cov} + {1'b0, proc_noise_ff};
   assign p1_sat      = cov_sum[COV_W] ? '1 : cov_sum[COV_W-1:0];
   assign rsp_free    = !rsp_valid_ff || rsp_ready;

   pbkf_state_ram u_state_ram (
      .clock   (clock),
      .reset   (reset),
      .ram_rd  (ram_rd),
      .ram_wr  (ram_wr),
      .rd_data (rd_data_w)
   );

   pbkf_gain_div u_gain_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .p1         (p1_ff),
      .meas_noise (meas_noise_ff),
      .done       (div_done),
      .gain       (gain)
   );

   pbkf_update u_update (
      .clock   (clock),
      .reset   (reset),
      .start   (upd_start),
      .gain    (gain),
      .est     (est_ff),
      .peak    (peak_ff),
      .p1      (p1_ff),
      .done    (upd_done),
      .est_new (est_new),
      .cov_new (cov_new)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && ch_in_range) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = burst_done ? ST_DIV_START : ST_IDLE;
         end
         ST_DIV_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (upd_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State machine outputs.
   always_comb begin
      req_ready   = 1'b0;
      ram_rd      = '0;
      ram_wr      = '0;
      div_start   = 1'b0;
      upd_start   = 1'b0;
      capture     = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            ram_rd.en   = req_valid && ch_in_range;
            ram_rd.addr = ch_idx;
         end
         ST_READ: begin
            if (burst_done) begin
               capture = 1'b1;
            end else begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = ch_ff;
               ram_wr.data = '{count: entry.count + COUNT_W'(1),
                               peak:  peak_new,
                               est:   entry.est,
                               cov:   entry.cov};
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
         end
         ST_DIV: begin
            upd_start = div_done;
         end
         ST_UPDATE: ;
         ST_WRITE: begin
            if (rsp_free) begin
               rsp_load    = 1'b1;
               ram_wr.en   = 1'b1;
               ram_wr.addr = ch_ff;
               ram_wr.data = '{count: '0, peak: '0, est: est_new, cov: cov_new};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_rd.en) begin
         ch_ff     <= ch_idx;
         sample_ff <= req_sample;
      end
      if (capture) begin
         peak_ff <= peak_new;
         est_ff  <= entry.est;
         p1_ff   <= p1_sat;
      end
   end

   // Result register: a finished result waits here for its transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_channel_ff <= CHAN_W'(ch_ff);
         rsp_value_ff   <= est_new;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_channel    = rsp_channel_ff;
   assign rsp_filtered_value = rsp_value_ff;

endmodule
`default_nettype wire

// ===== hdl/pbkf_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbkf_checker
// Port-level checks of the peak-burst Kalman filter, bound to the top level.
// ----------------------------------------------------------------------------
module pbkf_checker import pbkf_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [CHAN_W-1:0]     req_channel,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [CHAN_W-1:0]     rsp_out_channel,
   input logic [SAMPLE_W-1:0]   rsp_filtered_value
);

   logic chan_ok;

   assign chan_ok = ({2'b00, req_channel} < 5'(CHANNELS));

   // A pending result holds its payload until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_out_channel) && $stable(rsp_filtered_value))
      else $error("result changed before its transfer");

   // Only existing channels are ever reported.
   a_rsp_chan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({2'b00, rsp_out_channel} < 5'(CHANNELS)))
      else $error("result reports an unused channel");

   // A sample on a used channel holds off the input once it is transferred.
   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && chan_ok |=> !req_ready)
      else $error("input still ready right after a sample transfer");

   // A sample on an unused channel is dropped without stalling the input.
   a_drop_unused: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !chan_ok |=> req_ready)
      else $error("unused channel stalled the input");

   // A new result only comes out of the write-back, while the input is held off.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a write-back");

endmodule

bind peak_burst_kalman_filter pbkf_checker u_pbkf_checker (.*);
`default_nettype wire

// ===== bench/peak_burst_kalman_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_burst_kalman_filter_tb
// Self-checking bench for the per-channel burst peak Kalman filter. A driver
// sends channel-tagged samples in bursts with random gaps, while the result
// side stalls on changing patterns. Every accepted sample is run through a
// local fixed-point filter model, and each result transfer is checked against
// the oldest predicted estimate. The register settings change between phases.
// ----------------------------------------------------------------------------
module peak_burst_kalman_filter_tb;
   import pbkf_pkg::*;

   localparam int          CLOCK_HALF    = 2;
   localparam int          RESET_CYCLES  = 9;
   localparam int          DRAIN_CYCLES  = 40;
   localparam int          CYCLE_LIMIT   = 1000000;
   localparam int          RANDOM_ITEMS  = 1900;
   localparam int          MIN_RESULTS   = 48;
   localparam int          MAX_REPORTS   = 40;
   localparam logic [63:0] GAIN_ONE      = 64'd1 << K_FRAC;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [CHAN_W-1:0]   chan;
      logic [SAMPLE_W-1:0] level;
   } sample_item_type;

   typedef struct {
      logic [CHAN_W-1:0]   chan;
      logic [SAMPLE_W-1:0] estimate;
   } filter_result_type;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_RANDOM,
      RDY_PATTERN,
      RDY_HOLDOFF
   } stall_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CHAN_W-1:0]     req_channel = '0;
   logic [SAMPLE_W-1:0]   req_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CHAN_W-1:0]     rsp_out_channel;
   logic [SAMPLE_W-1:0]   rsp_filtered_value;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Local copy of the filter registers and the per-channel state.
   logic [COUNT_W-1:0] burst_len_cfg  = BURST_LEN_RST;
   logic [COV_W-1:0]   proc_noise_cfg = PROC_NOISE_RST;
   logic [COV_W-1:0]   meas_noise_cfg = MEAS_NOISE_RST;
   chan_entry_type     chan_state [CHANNELS];

   sample_item_type   sample_q [$];
   filter_result_type estimate_q [$];

   bit                  req_fire = 1'b0;
   int                  mismatch_count = 0;
   int                  results_seen = 0;
   int                  cycle_count = 0;
   int                  gap_left = 0;
   int                  burst_left = 0;
   int                  mode_left = 0;
   int                  holdoff_left = 0;
   stall_mode_type      stall_mode = RDY_ALWAYS;
   logic [7:0]          ready_pattern = 8'b1011_0110;
   logic [SAMPLE_W-1:0] est_predicted;
   filter_result_type   est_wanted;
   sample_item_type     next_item;

   peak_burst_kalman_filter i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_channel        (req_channel),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_filtered_value (rsp_filtered_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #(CLOCK_HALF) clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
      mismatch_count++;
   endtask

   // Updates the channel's burst tracking and, when the burst completes, runs
   // one Kalman step on its peak. Returns 1 when a result is due.
   function automatic bit kalman_update(input logic [CHAN_W-1:0] chan,
                                        input logic [SAMPLE_W-1:0] level,
                                        output logic [SAMPLE_W-1:0] new_est);
      chan_entry_type ent;
      logic [8:0]     need;
      logic [63:0]    p1;
      logic [63:0]    den;
      logic [63:0]    gain;
      logic [63:0]    mix;
      new_est = '0;
      if (chan >= CHANNELS) return 1'b0;
      ent = chan_state[chan];
      if (level > ent.peak) ent.peak = level;
      need = (burst_len_cfg == '0) ? 9'd1 : {1'b0, burst_len_cfg};
      if ({1'b0, ent.count} + 9'd1 < need) begin
         ent.count = ent.count + 1'b1;
         chan_state[chan] = ent;
         return 1'b0;
      end
      p1 = 64'(ent.cov) + 64'(proc_noise_cfg);
      if (p1 > 64'hFFFF_FFFF) p1 = 64'hFFFF_FFFF;
      den = p1 + 64'(meas_noise_cfg);
      gain = (den == 64'd0) ? 64'd0 : (p1 << K_FRAC) / den;
      if (gain > GAIN_ONE) gain = GAIN_ONE;
      mix = (64'(ent.est) * (GAIN_ONE - gain) + 64'(ent.peak) * gain) >> K_FRAC;
      ent.est   = mix[SAMPLE_W-1:0];
      ent.cov   = COV_W'((p1 * (GAIN_ONE - gain)) >> K_FRAC);
      ent.count = '0;
      ent.peak  = '0;
      chan_state[chan] = ent;
      new_est = ent.est;
      return 1'b1;
   endfunction

   // Result check first, then prediction for a sample accepted at this edge.
   always @(posedge clock) begin : watch_ports
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (estimate_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result ch %0d value %0d",
                                      rsp_out_channel, rsp_filtered_value));
         end else begin
            est_wanted = estimate_q.pop_front();
            if (rsp_out_channel !== est_wanted.chan) begin
               report_mismatch($sformatf("channel %0d, expected %0d",
                                         rsp_out_channel, est_wanted.chan));
            end
            if (rsp_filtered_value !== est_wanted.estimate) begin
               report_mismatch($sformatf("ch %0d estimate %0d, expected %0d",
                                         est_wanted.chan, rsp_filtered_value,
                                         est_wanted.estimate));
            end
         end
      end
      req_fire = !reset && req_valid && req_ready;
      if (req_fire) begin
         if (kalman_update(req_channel, req_sample, est_predicted)) begin
            estimate_q.push_back('{chan: req_channel, estimate: est_predicted});
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Sample driver: bursts of back-to-back transfers separated by idle gaps.
   always @(negedge clock) begin : drive_samples
      if (!reset && (!req_valid || req_fire)) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (sample_q.size() != 0) begin
            next_item = sample_q.pop_front();
            req_valid   <= 1'b1;
            req_channel <= next_item.chan;
            req_sample  <= next_item.level;
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                        : $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure in randomly chosen modes that change over the run.
   always @(negedge clock) begin : stall_results
      if (mode_left == 0) begin
         stall_mode    = stall_mode_type'($urandom_range(0, 3));
         mode_left     = $urandom_range(64, 512);
         ready_pattern = 8'($urandom()) | 8'h01;
         holdoff_left  = 0;
      end else begin
         mode_left--;
      end
      case (stall_mode)
         RDY_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         RDY_RANDOM: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         RDY_PATTERN: begin
            ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
            rsp_ready <= ready_pattern[0];
         end
         default: begin
            if (holdoff_left != 0) begin
               holdoff_left--;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
               holdoff_left = $urandom_range(5, 40);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_BURST_LEN:  burst_len_cfg  = data[COUNT_W-1:0];
         CSR_PROC_NOISE: proc_noise_cfg = data;
         CSR_MEAS_NOISE: meas_noise_cfg = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // The upper bits of the burst length write carry random junk.
   task automatic apply_filter_config(input logic [COUNT_W-1:0] burst,
                                      input logic [COV_W-1:0] q,
                                      input logic [COV_W-1:0] r);
      if ($urandom_range(0, 3) == 0) write_csr(CSR_UNUSED, $urandom());
      write_csr(CSR_BURST_LEN, {24'($urandom()), burst});
      write_csr(CSR_PROC_NOISE, q);
      write_csr(CSR_MEAS_NOISE, r);
   endtask

   task automatic queue_sample(input logic [CHAN_W-1:0] chan,
                               input logic [SAMPLE_W-1:0] level);
      sample_q.push_back('{chan: chan, level: level});
   endtask

   // A sample that yields no result may still be in flight after the last
   // result, so a DRAIN_CYCLES wait follows before the block counts as idle.
   task automatic wait_idle();
      while (sample_q.size() != 0 || req_valid || estimate_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : main_sequence
      int                  random_items;
      int                  phase_len;
      int                  hot_chan;
      logic [COUNT_W-1:0]  burst;
      logic [COV_W-1:0]    q;
      logic [COV_W-1:0]    r;
      logic [CHAN_W-1:0]   chan;
      logic [SAMPLE_W-1:0] level;

      random_items = 0;
      for (int i = 0; i < CHANNELS; i++) chan_state[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: unused channels are dropped, then one full burst.
      queue_sample(3'd7, 12'd4095);
      queue_sample(3'd6, 12'd0);
      queue_sample(3'd5, 12'd4095);
      queue_sample(3'd5, 12'd0);
      for (int i = 0; i < 14; i++) queue_sample(3'd5, 12'($urandom()));
      wait_idle();

      // A burst length of zero behaves as one.
      apply_filter_config(8'd0, PROC_NOISE_RST, MEAS_NOISE_RST);
      queue_sample(3'd0, 12'd4095);
      queue_sample(3'd1, 12'd0);
      queue_sample(3'd5, 12'd4095);
      queue_sample(3'd4, 12'd0);
      wait_idle();

      // No noise at all: a fresh channel hits a zero gain denominator, while
      // a channel with covariance left over gets a gain of exactly one.
      apply_filter_config(8'd1, 32'd0, 32'd0);
      queue_sample(3'd2, 12'd100);
      queue_sample(3'd0, 12'd2000);
      wait_idle();

      // Saturating noise, then the burst is shortened below the running count.
      apply_filter_config(8'd20, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < 3; i++) queue_sample(3'd3, 12'($urandom()));
      wait_idle();
      write_csr(CSR_BURST_LEN, 32'd2);
      queue_sample(3'd3, 12'd4095);
      wait_idle();

      while (random_items < RANDOM_ITEMS || results_seen < MIN_RESULTS) begin
         case ($urandom_range(0, 9))
            0:       burst = 8'd1;
            1:       burst = 8'd0;
            2:       burst = 8'd255;
            3, 4, 5: burst = 8'($urandom_range(2, 6));
            default: burst = 8'($urandom_range(7, 24));
         endcase
         case ($urandom_range(0, 7))
            0:       q = 32'd0;
            1:       q = 32'hFFFF_FFFF;
            2:       q = $urandom();
            3:       q = PROC_NOISE_RST;
            default: q = $urandom_range(0, 32'h00FF_FFFF);
         endcase
         case ($urandom_range(0, 7))
            0:       r = 32'd0;
            1:       r = 32'hFFFF_FFFF;
            2:       r = $urandom();
            3:       r = MEAS_NOISE_RST;
            default: r = $urandom_range(0, 32'h0FFF_FFFF);
         endcase
         apply_filter_config(burst, q, r);

         // Long bursts go mostly to one channel so that some of them finish.
         phase_len = (burst == 8'd255) ? 270 : $urandom_range(60, 180);
         hot_chan  = $urandom_range(0, CHANNELS - 1);
         for (int i = 0; i < phase_len; i++) begin
            if ($urandom_range(0, 15) == 0) begin
               chan = 3'($urandom_range(CHANNELS, 7));
            end else if (burst == 8'd255 && $urandom_range(0, 9) != 0) begin
               chan = 3'(hot_chan);
            end else begin
               chan = 3'($urandom_range(0, CHANNELS - 1));
            end
            case ($urandom_range(0, 7))
               0:       level = 12'd0;
               1:       level = 12'd4095;
               2:       level = 12'($urandom_range(0, 15));
               3:       level = 12'($urandom_range(4080, 4095));
               default: level = 12'($urandom());
            endcase
            queue_sample(chan, level);
            if (chan < CHANNELS) random_items++;
         end
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
